>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL. Empty when synthesising.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent holds: consequent holds in the same cycle
`define FCT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent holds: consequent holds in the next cycle
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FCT_ASSERT_SAME(lbl, ante, cons, msg)
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and constants of the frustum triangle clipper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package fct_pkg;

    // one vertex, Q16.16 per component
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vertex_t;

    localparam int VERTEX_W     = 96;
    localparam int PLANE_COUNT  = 6;
    localparam int RESULT_LIMIT = 8;
    localparam int DIV_STEPS    = 16;

    // plane codes, in clipping order
    localparam logic [2:0] PL_LEFT   = 3'd0;
    localparam logic [2:0] PL_RIGHT  = 3'd1;
    localparam logic [2:0] PL_TOP    = 3'd2;
    localparam logic [2:0] PL_BOTTOM = 3'd3;
    localparam logic [2:0] PL_NEAR   = 3'd4;
    localparam logic [2:0] PL_FAR    = 3'd5;

    // configuration register indexes
    localparam logic [2:0] REG_COS_X = 3'd0;
    localparam logic [2:0] REG_SIN_X = 3'd1;
    localparam logic [2:0] REG_COS_Y = 3'd2;
    localparam logic [2:0] REG_SIN_Y = 3'd3;
    localparam logic [2:0] REG_NEAR  = 3'd4;
    localparam logic [2:0] REG_FAR   = 3'd5;

endpackage

>>> rtl/fct_ram.sv
// ----------------------------------------------------------------------------
// fct_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fct_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/frustum_triangle_clipper_core.sv
// Sequence: per triangle the three vertices are loaded, then each plane pass reads every vertex
//   and forms its distance; an edge crossing adds a 16 step divider, three interpolations and a push;
//   fan results follow the last pass, each held until out_ready takes it.
// Throughput: one triangle at a time, set by the shared multiplier and divider.
// Reset: asynchronous active low; configuration registers to defaults, vertex counts cleared.
// ----------------------------------------------------------------------------
// frustum_triangle_clipper_core
// Sutherland-Hodgman clipping against six frustum planes, fan output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module frustum_triangle_clipper_core #(
    parameter int MAX_VERTICES = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] c_x,
    input  logic signed [31:0] c_y,
    input  logic signed [31:0] c_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] p_x,
    output logic signed [31:0] p_y,
    output logic signed [31:0] p_z,
    output logic signed [31:0] q_x,
    output logic signed [31:0] q_y,
    output logic signed [31:0] q_z,
    output logic signed [31:0] r_x,
    output logic signed [31:0] r_y,
    output logic signed [31:0] r_z,
    output logic               last_triangle,
    output logic               none_left
);
    import fct_pkg::*;

    localparam int CW    = $clog2(MAX_VERTICES + 1);
    localparam int CW1   = CW + 1;
    localparam int DEPTH = 2 * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);

    // sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LOAD  = 5'd1;
    localparam logic [4:0] S_PASS  = 5'd2;
    localparam logic [4:0] S_RWAIT = 5'd3;
    localparam logic [4:0] S_M1    = 5'd4;
    localparam logic [4:0] S_M2    = 5'd5;
    localparam logic [4:0] S_DSUM  = 5'd6;
    localparam logic [4:0] S_DEC   = 5'd7;
    localparam logic [4:0] S_DIV   = 5'd8;
    localparam logic [4:0] S_IX    = 5'd9;
    localparam logic [4:0] S_IY    = 5'd10;
    localparam logic [4:0] S_IZ    = 5'd11;
    localparam logic [4:0] S_IW    = 5'd12;
    localparam logic [4:0] S_PUSHX = 5'd13;
    localparam logic [4:0] S_KEEP  = 5'd14;
    localparam logic [4:0] S_OUT0  = 5'd15;
    localparam logic [4:0] S_OR0   = 5'd16;
    localparam logic [4:0] S_OP    = 5'd17;
    localparam logic [4:0] S_OR1   = 5'd18;
    localparam logic [4:0] S_OQ    = 5'd19;
    localparam logic [4:0] S_OR2   = 5'd20;
    localparam logic [4:0] S_OR    = 5'd21;
    localparam logic [4:0] S_OWAIT = 5'd22;

    logic [4:0]  state_reg;
    logic [16:0] cos_x_reg, sin_x_reg, cos_y_reg, sin_y_reg;
    logic [30:0] near_reg, far_reg;

    vertex_t     in_vtx_reg [3];
    vertex_t     cur_reg, prev_reg, ix_reg;
    logic [CW-1:0] cnt_reg [2];
    logic [CW-1:0] idx_reg;
    logic [2:0]  plane_reg;
    logic        src_reg;
    logic        first_reg;
    logic signed [51:0] prod_reg, acc_reg, dprev_reg, dcur_reg;
    logic [53:0] rem_reg, den_reg;
    logic [15:0] t_reg;
    logic [3:0]  step_reg;
    logic [2:0]  k_reg;
    logic [AW-1:0] rd_addr_reg;

    vertex_t     out_p_reg, out_q_reg, out_r_reg;
    logic        out_valid_reg, last_reg, none_reg;

    // RAM ports
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    vertex_t       wr_data;
    vertex_t       rd_data;
    logic [VERTEX_W-1:0] rd_bits;

    // shared multiplier
    logic signed [33:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [51:0] mul_p;

    logic signed [51:0] dist_val;
    logic [51:0]        abs_prev, abs_cur;
    logic [53:0]        rem_shift;
    logic [CW-1:0]      n_src;
    logic               dst;
    logic [CW-1:0]      cnt_dst;
    logic               room;
    logic signed [31:0] interp;
    logic               is_last;
    logic               cnt_in_range;

    fct_ram #(
        .WIDTH(VERTEX_W),
        .DEPTH(DEPTH)
    ) u_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr_reg),
        .rd_data(rd_bits)
    );
    assign rd_data = vertex_t'(rd_bits);

    function automatic logic [AW-1:0] bank_addr(input logic bank, input logic [CW-1:0] idx);
        logic [AW-1:0] base;
        base = bank ? AW'(MAX_VERTICES) : '0;
        return base + AW'(idx);
    endfunction

    assign dst     = ~src_reg;
    assign n_src   = cnt_reg[src_reg];
    assign cnt_dst = cnt_reg[dst];
    assign room    = (CW1'(cnt_dst) < CW1'(MAX_VERTICES));

    // multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_M1:
            begin
                if (plane_reg == PL_LEFT || plane_reg == PL_RIGHT)
                begin
                    mul_a = 34'(rd_data.x);
                    mul_b = $signed({1'b0, cos_x_reg});
                end
                else
                begin
                    mul_a = 34'(rd_data.y);
                    mul_b = $signed({1'b0, cos_y_reg});
                end
            end
            S_M2:
            begin
                mul_a = 34'(cur_reg.z);
                mul_b = (plane_reg == PL_LEFT || plane_reg == PL_RIGHT) ?
                        $signed({1'b0, sin_x_reg}) : $signed({1'b0, sin_y_reg});
            end
            S_IX:
            begin
                mul_a = 34'(cur_reg.x) - 34'(prev_reg.x);
                mul_b = $signed({2'b00, t_reg});
            end
            S_IY:
            begin
                mul_a = 34'(cur_reg.y) - 34'(prev_reg.y);
                mul_b = $signed({2'b00, t_reg});
            end
            S_IZ:
            begin
                mul_a = 34'(cur_reg.z) - 34'(prev_reg.z);
                mul_b = $signed({2'b00, t_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // plane distance: from the accumulated products for the side planes, from z for near and far
    always_comb
    begin
        case (plane_reg)
            PL_NEAR: dist_val = 52'(cur_reg.z) - $signed({21'b0, near_reg});
            PL_FAR:  dist_val = $signed({21'b0, far_reg}) - 52'(cur_reg.z);
            default: dist_val = acc_reg + prod_reg;
        endcase
    end

    assign abs_prev  = dprev_reg[51] ? 52'(-dprev_reg) : 52'(dprev_reg);
    assign abs_cur   = dcur_reg[51] ? 52'(-dcur_reg) : 52'(dcur_reg);
    assign rem_shift = {rem_reg[52:0], 1'b0};
    // floor of the Q16 product, added to the previous vertex
    assign interp    = 32'(prod_reg >>> 16);
    assign is_last   = (CW1'(k_reg) + CW1'(3) == CW1'(cnt_reg[0])) ||
                       (k_reg == 3'(RESULT_LIMIT - 1));
    assign cnt_in_range = (CW1'(cnt_reg[0]) <= CW1'(MAX_VERTICES)) &&
                          (CW1'(cnt_reg[1]) <= CW1'(MAX_VERTICES));

    // store write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = bank_addr(dst, cnt_dst);
        wr_data = cur_reg;
        case (state_reg)
            S_LOAD:
            begin
                wr_en   = 1'b1;
                wr_addr = bank_addr(1'b0, idx_reg);
                wr_data = in_vtx_reg[idx_reg[1:0]];
            end
            S_PUSHX:
            begin
                wr_en   = room;
                wr_data = ix_reg;
            end
            S_KEEP:
            begin
                wr_en = room && !dcur_reg[51] && (dcur_reg != '0);
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_x_reg <= 17'd46341;
            sin_x_reg <= 17'd46341;
            cos_y_reg <= 17'd46341;
            sin_y_reg <= 17'd46341;
            near_reg  <= 31'd65536;
            far_reg   <= 31'd6553600;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COS_X: cos_x_reg <= cfg_data[16:0];
                REG_SIN_X: sin_x_reg <= cfg_data[16:0];
                REG_COS_Y: cos_y_reg <= cfg_data[16:0];
                REG_SIN_Y: sin_y_reg <= cfg_data[16:0];
                REG_NEAR:  near_reg  <= cfg_data;
                REG_FAR:   far_reg   <= cfg_data;
                default:   ;
            endcase
        end
    end

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg[0]    <= '0;
            cnt_reg[1]    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == CW'(2))
                    begin
                        cnt_reg[0] <= CW'(3);
                        plane_reg  <= PL_LEFT;
                        src_reg    <= 1'b0;
                        state_reg  <= S_PASS;
                    end
                end
                S_PASS:
                begin
                    cnt_reg[dst] <= '0;
                    if (n_src == '0)
                    begin
                        src_reg   <= dst;
                        plane_reg <= plane_reg + 1'b1;
                        state_reg <= (plane_reg == 3'(PLANE_COUNT - 1)) ? S_OUT0 : S_PASS;
                    end
                    else
                    begin
                        first_reg   <= 1'b1;
                        idx_reg     <= '0;
                        rd_addr_reg <= bank_addr(src_reg, n_src - 1'b1);
                        state_reg   <= S_RWAIT;
                    end
                end
                S_RWAIT:
                begin
                    state_reg <= S_M1;
                end
                S_M1:
                begin
                    cur_reg   <= rd_data;
                    prod_reg  <= mul_p;
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    acc_reg   <= (plane_reg == PL_RIGHT || plane_reg == PL_TOP) ?
                                 -prod_reg : prod_reg;
                    prod_reg  <= mul_p;
                    state_reg <= S_DSUM;
                end
                S_DSUM:
                begin
                    if (first_reg)
                    begin
                        first_reg   <= 1'b0;
                        prev_reg    <= cur_reg;
                        dprev_reg   <= dist_val;
                        rd_addr_reg <= bank_addr(src_reg, '0);
                        state_reg   <= S_RWAIT;
                    end
                    else
                    begin
                        dcur_reg  <= dist_val;
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    // strict sign change between previous and current vertex
                    if ((!dprev_reg[51] && dprev_reg != '0 && dcur_reg[51]) ||
                        (dprev_reg[51] && !dcur_reg[51] && dcur_reg != '0))
                    begin
                        rem_reg   <= 54'(abs_prev);
                        den_reg   <= 54'(abs_prev) + 54'(abs_cur);
                        t_reg     <= '0;
                        step_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        state_reg <= S_KEEP;
                    end
                end
                S_DIV:
                begin
                    // one restoring division step per cycle
                    if (rem_shift >= den_reg)
                    begin
                        rem_reg <= rem_shift - den_reg;
                        t_reg   <= {t_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_shift;
                        t_reg   <= {t_reg[14:0], 1'b0};
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 4'(DIV_STEPS - 1))
                    begin
                        state_reg <= S_IX;
                    end
                end
                S_IX:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_IY;
                end
                S_IY:
                begin
                    ix_reg.x  <= prev_reg.x + interp;
                    prod_reg  <= mul_p;
                    state_reg <= S_IZ;
                end
                S_IZ:
                begin
                    ix_reg.y  <= prev_reg.y + interp;
                    prod_reg  <= mul_p;
                    state_reg <= S_IW;
                end
                S_IW:
                begin
                    ix_reg.z  <= prev_reg.z + interp;
                    state_reg <= S_PUSHX;
                end
                S_PUSHX:
                begin
                    if (room)
                    begin
                        cnt_reg[dst] <= cnt_dst + 1'b1;
                    end
                    state_reg <= S_KEEP;
                end
                S_KEEP:
                begin
                    if (room && !dcur_reg[51] && (dcur_reg != '0))
                    begin
                        cnt_reg[dst] <= cnt_dst + 1'b1;
                    end
                    prev_reg  <= cur_reg;
                    dprev_reg <= dcur_reg;
                    idx_reg   <= idx_reg + 1'b1;
                    if (idx_reg + 1'b1 == n_src)
                    begin
                        src_reg   <= dst;
                        plane_reg <= plane_reg + 1'b1;
                        state_reg <= (plane_reg == 3'(PLANE_COUNT - 1)) ? S_OUT0 : S_PASS;
                    end
                    else
                    begin
                        rd_addr_reg <= bank_addr(src_reg, idx_reg + 1'b1);
                        state_reg   <= S_RWAIT;
                    end
                end
                S_OUT0:
                begin
                    k_reg <= '0;
                    if (CW1'(cnt_reg[0]) < CW1'(3))
                    begin
                        out_p_reg     <= '0;
                        out_q_reg     <= '0;
                        out_r_reg     <= '0;
                        last_reg      <= 1'b1;
                        none_reg      <= 1'b1;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OWAIT;
                    end
                    else
                    begin
                        rd_addr_reg <= bank_addr(1'b0, '0);
                        state_reg   <= S_OR0;
                    end
                end
                S_OR0:
                begin
                    state_reg <= S_OP;
                end
                S_OP:
                begin
                    out_p_reg   <= rd_data;
                    rd_addr_reg <= bank_addr(1'b0, CW'(1));
                    state_reg   <= S_OR1;
                end
                S_OR1:
                begin
                    state_reg <= S_OQ;
                end
                S_OQ:
                begin
                    out_q_reg   <= rd_data;
                    rd_addr_reg <= bank_addr(1'b0, CW'(k_reg) + CW'(2));
                    state_reg   <= S_OR2;
                end
                S_OR2:
                begin
                    state_reg <= S_OR;
                end
                S_OR:
                begin
                    out_r_reg     <= rd_data;
                    last_reg      <= is_last;
                    none_reg      <= 1'b0;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OWAIT;
                end
                S_OWAIT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            k_reg       <= k_reg + 1'b1;
                            rd_addr_reg <= bank_addr(1'b0, CW'(k_reg) + CW'(2));
                            state_reg   <= S_OR1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // input beat capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_vtx_reg[0] <= '{x: a_x, y: a_y, z: a_z};
            in_vtx_reg[1] <= '{x: b_x, y: b_y, z: b_z};
            in_vtx_reg[2] <= '{x: c_x, y: c_y, z: c_z};
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign p_x           = out_p_reg.x;
    assign p_y           = out_p_reg.y;
    assign p_z           = out_p_reg.z;
    assign q_x           = out_q_reg.x;
    assign q_y           = out_q_reg.y;
    assign q_z           = out_q_reg.z;
    assign r_x           = out_r_reg.x;
    assign r_y           = out_r_reg.y;
    assign r_z           = out_r_reg.z;
    assign last_triangle = last_reg;
    assign none_left     = none_reg;

    // checks
    `FCT_ASSERT_SAME(a_idle_no_out, in_ready, !out_valid, "result beat while idle")
    `FCT_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready after accept")
    `FCT_ASSERT_SAME(a_none_is_last, out_valid && none_left, last_triangle, "none not last")
    `FCT_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_in_range, "vertex count overflow")

endmodule
